// ===== sv/icph_pkg.sv =====
// Package for the pseudo-header internet checksum block.
// Holds field codes, request and result types and the ones' complement add.
// No dependencies.
`default_nettype none

package icph_pkg;

  localparam int LenBits = 20;

  localparam logic [1:0] PartSkip    = 2'd0;
  localparam logic [1:0] PartAddr    = 2'd1;
  localparam logic [1:0] PartPayload = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] part;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic        odd_length;
  } out_item_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/icph_accum.sv =====
// Packet accumulator: running ones' complement sum, byte pairing and payload count.
// Produces the folded, inverted checksum for a request marked last.
// Depends on icph_pkg.
`default_nettype none

module icph_accum (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire icph_pkg::in_item_t   item_i,
  input  wire logic [7:0]           proto_i,
  output icph_pkg::out_item_t       res_o
);

  logic [15:0]                  sum_q, sum_d;
  logic                         low_next_q, low_next_d;
  logic [7:0]                   held_q, held_d;
  logic [icph_pkg::LenBits-1:0] count_q, count_d;

  logic        is_data;
  logic        pair_hit;
  logic [15:0] add_word;
  logic [31:0] len_ext;
  logic [18:0] total;
  logic [16:0] fold1;
  logic [16:0] fold2;

  always_comb begin
    is_data  = (item_i.part == icph_pkg::PartAddr) || (item_i.part == icph_pkg::PartPayload);
    pair_hit = is_data && low_next_q;

    // pair word, or the zero-padded current or pending high byte for the end-of-packet total
    if (pair_hit) begin
      add_word = {held_q, item_i.data_byte};
    end else if (is_data) begin
      add_word = {item_i.data_byte, 8'd0};
    end else if (low_next_q) begin
      add_word = {held_q, 8'd0};
    end else begin
      add_word = 16'd0;
    end

    count_d = count_q;
    if ((item_i.part == icph_pkg::PartPayload) && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end

    len_ext = 32'(count_d);
    total   = 19'(sum_q) + 19'(add_word) + 19'(len_ext[15:0]) + 19'(len_ext[31:16])
            + 19'(proto_i);
    fold1   = {1'b0, total[15:0]} + 17'(total[18:16]);
    fold2   = {1'b0, fold1[15:0]} + 17'(fold1[16]);

    res_o.checksum_value = ~fold2[15:0];
    res_o.odd_length     = count_d[0];

    if (item_i.last) begin
      sum_d      = 16'd0;
      low_next_d = 1'b0;
      held_d     = 8'd0;
      count_d    = '0;
    end else begin
      sum_d      = pair_hit ? icph_pkg::oc_add(sum_q, add_word) : sum_q;
      low_next_d = is_data ? !low_next_q : low_next_q;
      held_d     = pair_hit ? 8'd0 : (is_data ? item_i.data_byte : held_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= 16'd0;
      low_next_q <= 1'b0;
      held_q     <= 8'd0;
      count_q    <= '0;
    end else if (step_i) begin
      sum_q      <= sum_d;
      low_next_q <= low_next_d;
      held_q     <= held_d;
      count_q    <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/internet_checksum_pseudo_header.sv =====
// A result is offered from the output register once its last byte leaves stage one.
// One byte per cycle unless a last byte waits; the per-byte work is one 16-bit add
// between the input register and the packet state, the final fold one add tree.
// A full output register stalls only a byte marked last waiting behind it.
// Reset clears the sum, pairing, payload count and both stages; protocol resets to 6.
`default_nettype none

module internet_checksum_pseudo_header (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire icph_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output icph_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [7:0]           cfg_data_i
);

  logic                s1_valid_q, s1_valid_d;
  icph_pkg::in_item_t  s1_q;
  logic                out_valid_q, out_valid_d;
  icph_pkg::out_item_t out_q;
  logic [7:0]          proto_q;

  logic                out_free;
  logic                s1_adv;
  logic                in_acc;
  icph_pkg::out_item_t res;

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    s1_adv      = s1_valid_q && (!s1_q.last || out_free);
    in_ready_o  = !s1_valid_q || s1_adv;
    in_acc      = in_valid_i && in_ready_o;
    s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    if (s1_adv && s1_q.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
    cfg_ready_o = 1'b1;
  end

  icph_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .item_i  (s1_q),
    .proto_i (proto_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      proto_q     <= 8'd6;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        proto_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s1_adv && s1_q.last) begin
      out_q <= res;
    end
  end

  a_rise_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.last))
    else $error("result raised without a last request in stage one");

  a_nonlast_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_q.last) |-> s1_adv)
    else $error("non-last request stalled in stage one");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.last && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("last request dropped while result pending");

endmodule

`default_nettype wire

// ===== test/internet_checksum_pseudo_header_checker.sv =====
`timescale 1ns / 100ps
// Checker for internet_checksum_pseudo_header: watches the request, result and
// protocol write channels, predicts each checksum and compares it field by field.
// Depends on icph_pkg.
module internet_checksum_pseudo_header_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  icph_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  icph_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [7:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  logic [7:0]                   protocol_q = 8'd6;
  logic [15:0]                  sum_q = '0;
  logic                         high_held_q = 1'b0;
  logic [7:0]                   high_byte_q = '0;
  logic [icph_pkg::LenBits-1:0] payload_len_q = '0;
  icph_pkg::out_item_t          checksum_q[$];
  int                           fails = 0;
  int                           checked = 0;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [15:0]         total;
    logic [31:0]         len;
    icph_pkg::out_item_t want;
    if (!rst_ni) begin
      protocol_q    = 8'd6;
      sum_q         = '0;
      high_held_q   = 1'b0;
      high_byte_q   = '0;
      payload_len_q = '0;
      checksum_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        protocol_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (checksum_q.size() == 0) begin
          $error("unexpected result: checksum_value %h odd_length %b",
                 out_data_i.checksum_value, out_data_i.odd_length);
          fails++;
        end else begin
          want = checksum_q.pop_front();
          checked++;
          if (out_data_i.checksum_value !== want.checksum_value) begin
            $error("checksum_value: expected %h, got %h",
                   want.checksum_value, out_data_i.checksum_value);
            fails++;
          end
          if (out_data_i.odd_length !== want.odd_length) begin
            $error("odd_length: expected %b, got %b",
                   want.odd_length, out_data_i.odd_length);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.part == icph_pkg::PartAddr || in_data_i.part == icph_pkg::PartPayload) begin
          if (high_held_q) begin
            sum_q       = ones_add(sum_q, {high_byte_q, in_data_i.data_byte});
            high_held_q = 1'b0;
            high_byte_q = '0;
          end else begin
            high_byte_q = in_data_i.data_byte;
            high_held_q = 1'b1;
          end
          if (in_data_i.part == icph_pkg::PartPayload && payload_len_q != '1) begin
            payload_len_q++;
          end
        end
        if (in_data_i.last) begin
          // pad, then length halves and protocol
          len   = 32'(payload_len_q);
          total = sum_q;
          if (high_held_q) begin
            total = ones_add(total, {high_byte_q, 8'h00});
          end
          total = ones_add(total, len[15:0]);
          total = ones_add(total, len[31:16]);
          total = ones_add(total, {8'h00, protocol_q});
          want.checksum_value = ~total;
          want.odd_length     = len[0];
          checksum_q.push_back(want);
          sum_q         = '0;
          high_held_q   = 1'b0;
          high_byte_q   = '0;
          payload_len_q = '0;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= checksum_q.size();
    checked_o    <= checked;
  end

endmodule

// ===== test/internet_checksum_pseudo_header_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for internet_checksum_pseudo_header: directed and random byte
// streams, protocol writes and random stalls on both sides; gives the verdict.
// Depends on icph_pkg, the block and internet_checksum_pseudo_header_checker.
module internet_checksum_pseudo_header_tb;

  localparam logic [1:0] PartSpare   = 2'd3;
  localparam int         StallLimit  = 2000;
  localparam int         DrainCycles = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  icph_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  icph_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i = '0;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int packets = 0;
  int quiet_cycles = 0;

  internet_checksum_pseudo_header dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  internet_checksum_pseudo_header_checker check_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("Watchdog: %0d cycles without a handshake", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request per call; valid held until accepted
  task automatic send_byte(input logic [7:0] value, input logic [1:0] tag, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: value, part: tag, last: is_last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    if (is_last) packets++;
  endtask

  task automatic send_packet(input int n_skip, input int n_addr, input int n_payload);
    int         total;
    logic [1:0] tag;
    total = n_skip + n_addr + n_payload;
    if (total == 0) send_byte(8'($urandom_range(255)), icph_pkg::PartSkip, 1'b1);
    for (int i = 0; i < total; i++) begin
      tag = (i < n_skip) ? icph_pkg::PartSkip :
            (i < n_skip + n_addr) ? icph_pkg::PartAddr : icph_pkg::PartPayload;
      send_byte(8'($urandom_range(255)), tag, i == total - 1);
    end
  endtask

  task automatic random_traffic(input int n_items);
    int goal;
    int n_addr;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          case ($urandom_range(3))
            0, 1: n_addr = 8;
            2: n_addr = 32;
            default: n_addr = $urandom_range(9);
          endcase
          send_packet($urandom_range(1) ? 0 : $urandom_range(1, 20), n_addr,
                      ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(12));
        end
        7, 8: begin
          send_byte(8'($urandom_range(255)), 2'($urandom_range(3)), $urandom_range(3) == 0);
        end
        default: begin
          // broken packet: mixed tags, last on any tag
          repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(255)), 2'($urandom_range(1, 2)), 1'b0);
          end
          send_byte(8'($urandom_range(255)), 2'($urandom_range(3)), 1'b1);
        end
      endcase
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_protocol(input logic [7:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // protocol at its reset value
    send_byte(8'h00, icph_pkg::PartSkip, 1'b1);
    send_byte(8'hFF, icph_pkg::PartAddr, 1'b0);
    send_byte(8'hFF, icph_pkg::PartAddr, 1'b0);
    send_byte(8'hFF, icph_pkg::PartPayload, 1'b1);
    send_byte(8'h80, icph_pkg::PartPayload, 1'b0);
    send_byte(8'h01, icph_pkg::PartPayload, 1'b0);
    send_byte(8'hFE, PartSpare, 1'b0);
    send_byte(8'h7F, icph_pkg::PartAddr, 1'b1);
    send_byte(8'hAB, PartSpare, 1'b1);
    send_byte(8'hC0, icph_pkg::PartAddr, 1'b0);
    send_byte(8'hA8, icph_pkg::PartAddr, 1'b0);
    send_byte(8'h01, icph_pkg::PartAddr, 1'b0);
    send_byte(8'h55, icph_pkg::PartPayload, 1'b0);
    send_byte(8'hAA, icph_pkg::PartPayload, 1'b1);
    send_byte(8'h00, icph_pkg::PartPayload, 1'b0);
    send_byte(8'h00, icph_pkg::PartPayload, 1'b1);
    repeat (4) send_byte(8'hFF, icph_pkg::PartPayload, 1'b0);
    send_byte(8'hFF, icph_pkg::PartSkip, 1'b1);

    write_protocol(8'hFF);
    send_idle_pct = 21;
    recv_idle_pct = 62;
    random_traffic(400);

    write_protocol(8'h00);
    send_idle_pct = 62;
    recv_idle_pct = 21;
    random_traffic(400);

    write_protocol(8'd17);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(400);
    drain();

    $display("Sent %0d bytes in %0d packets; %0d checksums compared, protocol 6/255/0/17,",
             bytes_sent, packets, checked);
    $display("with stalls on either side in both proportions, then back to back.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
